/* rtl/gamepad_remap_with_chord_detect_assert.svh */
// Assertion macros for the gamepad remap block
`ifndef GAMEPAD_REMAP_WITH_CHORD_DETECT_ASSERT_SVH
`define GAMEPAD_REMAP_WITH_CHORD_DETECT_ASSERT_SVH

// Check on every clock edge outside reset
`define GRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define GRC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/grc_pkg.sv */
package grc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  TRIG_THRESHOLD = 8'd30;
    localparam logic [7:0]  TRIG_FULL      = 8'hFF;
    localparam logic [15:0] GUIDE_BIT      = 16'h0400;
    localparam logic [4:0]  CODE_NONE      = 5'd0;
    localparam logic [4:0]  CODE_LT        = 5'd15;
    localparam logic [4:0]  CODE_RT        = 5'd16;
    localparam logic [4:0]  CODE_MAX       = 5'd16;
    localparam logic [2:0]  HELD_MAX       = 3'd7;

    localparam logic [2:0] REG_REMAP_ENABLE   = 3'd0;
    localparam logic [2:0] REG_MAP_LOW        = 3'd1;
    localparam logic [2:0] REG_MAP_HIGH       = 3'd2;
    localparam logic [2:0] REG_CHORD_ENABLE   = 3'd3;
    localparam logic [2:0] REG_CHORD_FIRST    = 3'd4;
    localparam logic [2:0] REG_CHORD_SECOND   = 3'd5;
    localparam logic [2:0] REG_HOLD_POLLS     = 3'd6;
    localparam logic [2:0] REG_COOLDOWN_POLLS = 3'd7;

    localparam logic        RST_REMAP_ENABLE   = 1'b1;
    localparam logic [39:0] RST_MAP_LOW        = 40'd282600803393;
    localparam logic [39:0] RST_MAP_HIGH       = 40'd566345739593;
    localparam logic        RST_CHORD_ENABLE   = 1'b0;
    localparam logic [4:0]  RST_CHORD_FIRST    = 5'd10;
    localparam logic [4:0]  RST_CHORD_SECOND   = 5'd0;
    localparam logic [2:0]  RST_HOLD_POLLS     = 3'd3;
    localparam logic [5:0]  RST_COOLDOWN_POLLS = 6'd30;

    typedef struct packed {
        logic        remap_enable;
        logic [39:0] map_low;
        logic [39:0] map_high;
        logic        chord_enable;
        logic [4:0]  chord_first;
        logic [4:0]  chord_second;
        logic [2:0]  hold_polls;
        logic [5:0]  cooldown_polls;
    } t_cfg;

    typedef struct packed {
        logic [15:0]        buttons;
        logic [7:0]         lt_level;
        logic [7:0]         rt_level;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic               suppressed;
        logic               fire;
    } t_item;

    typedef struct packed {
        logic [15:0]        buttons;
        logic [7:0]         lt_level;
        logic [7:0]         rt_level;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic               menu_fire;
    } t_result;

    function automatic logic [15:0] code_bit(input logic [4:0] code);
        logic [15:0] b;
        case (code)
            5'd1:    b = 16'h1000;
            5'd2:    b = 16'h2000;
            5'd3:    b = 16'h4000;
            5'd4:    b = 16'h8000;
            5'd5:    b = 16'h0100;
            5'd6:    b = 16'h0200;
            5'd7:    b = 16'h0040;
            5'd8:    b = 16'h0080;
            5'd9:    b = 16'h0010;
            5'd10:   b = 16'h0020;
            5'd11:   b = 16'h0001;
            5'd12:   b = 16'h0002;
            5'd13:   b = 16'h0004;
            5'd14:   b = 16'h0008;
            default: b = 16'h0000;
        endcase
        return b;
    endfunction

    function automatic logic code_valid(input logic [4:0] code);
        return (code != CODE_NONE) && (code <= CODE_MAX);
    endfunction

    function automatic logic is_held(input logic [4:0] code, input logic [15:0] btn,
                                     input logic [7:0] lt, input logic [7:0] rt);
        logic h;
        if (!code_valid(code)) begin
            h = 1'b0;
        end else if (code == CODE_LT) begin
            h = (lt >= TRIG_THRESHOLD);
        end else if (code == CODE_RT) begin
            h = (rt >= TRIG_THRESHOLD);
        end else begin
            h = |(btn & code_bit(code));
        end
        return h;
    endfunction

    function automatic logic [7:0] level_of(input logic [4:0] code, input logic [15:0] btn,
                                            input logic [7:0] lt, input logic [7:0] rt);
        logic [7:0] v;
        if (code == CODE_LT) begin
            v = lt;
        end else if (code == CODE_RT) begin
            v = rt;
        end else begin
            v = is_held(code, btn, lt, rt) ? TRIG_FULL : 8'd0;
        end
        return v;
    endfunction

endpackage

/* rtl/grc_front.sv */
module grc_front
    import grc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_pad_slot,
    input  logic [15:0]        i_raw_buttons,
    input  logic [7:0]         i_raw_left_trigger,
    input  logic [7:0]         i_raw_right_trigger,
    input  logic signed [15:0] i_stick_lx,
    input  logic signed [15:0] i_stick_ly,
    input  logic signed [15:0] i_stick_rx,
    input  logic signed [15:0] i_stick_ry,
    input  logic               i_guest_suppressed,
    input  logic               i_queue_ready,
    output logic               o_push,
    output t_item              o_item
);

    logic       r_latched, n_latched;
    logic [2:0] r_held,    n_held;
    logic [5:0] r_cooldown, n_cooldown;

    logic        active, no_chord, v0, v1, down, fire;
    logic [15:0] clear_bits, btn;
    logic [5:0]  cd_dec;
    logic        latched_mid;

    assign o_ready = i_queue_ready;
    assign o_push  = i_valid && i_queue_ready;

    always_comb begin
        active      = i_cfg.chord_enable && (i_pad_slot == 2'd0);
        no_chord    = (i_cfg.chord_first == CODE_NONE) && (i_cfg.chord_second == CODE_NONE);
        v0          = code_valid(i_cfg.chord_first);
        v1          = code_valid(i_cfg.chord_second);
        down        = (v0 || v1)
                    && (!v0 || is_held(i_cfg.chord_first, i_raw_buttons,
                                       i_raw_left_trigger, i_raw_right_trigger))
                    && (!v1 || is_held(i_cfg.chord_second, i_raw_buttons,
                                       i_raw_left_trigger, i_raw_right_trigger));
        clear_bits  = (v0 ? code_bit(i_cfg.chord_first) : 16'h0000)
                    | (v1 ? code_bit(i_cfg.chord_second) : 16'h0000);
        cd_dec      = (r_cooldown != 6'd0) ? r_cooldown - 6'd1 : 6'd0;
        latched_mid = down ? r_latched : 1'b0;
        fire        = !latched_mid && down && (r_held != HELD_MAX)
                    && (({1'b0, r_held} + 4'd1) == {1'b0, i_cfg.hold_polls})
                    && (cd_dec == 6'd0);

        btn        = i_raw_buttons;
        n_latched  = r_latched;
        n_held     = r_held;
        n_cooldown = r_cooldown;
        if (active && no_chord) begin
            n_latched = 1'b0;
            fire      = 1'b0;
        end else if (active) begin
            if (down) begin
                btn = i_raw_buttons & ~clear_bits;
            end
            n_held     = down ? ((r_held != HELD_MAX) ? r_held + 3'd1 : r_held) : 3'd0;
            n_latched  = fire ? 1'b1 : latched_mid;
            n_cooldown = fire ? i_cfg.cooldown_polls : cd_dec;
        end else begin
            fire = 1'b0;
        end

        o_item.buttons    = btn;
        o_item.lt_level   = i_raw_left_trigger;
        o_item.rt_level   = i_raw_right_trigger;
        o_item.lx         = i_stick_lx;
        o_item.ly         = i_stick_ly;
        o_item.rx         = i_stick_rx;
        o_item.ry         = i_stick_ry;
        o_item.suppressed = i_guest_suppressed;
        o_item.fire       = fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched  <= 1'b0;
            r_held     <= 3'd0;
            r_cooldown <= 6'd0;
        end else if (o_push) begin
            r_latched  <= n_latched;
            r_held     <= n_held;
            r_cooldown <= n_cooldown;
        end
    end

endmodule

/* rtl/grc_queue.sv */
module grc_queue
    import grc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* rtl/grc_back.sv */
module grc_back
    import grc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_head_valid,
    input  t_item   i_head,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic       r_valid;
    t_result    r_result, n_result;
    logic [79:0] map;
    logic [4:0]  dcode [16];
    logic        ident;

    assign o_pop    = i_head_valid && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign map      = {i_cfg.map_high, i_cfg.map_low};

    always_comb begin
        ident = 1'b1;
        for (int d = 0; d < 16; d++) begin
            dcode[d] = map[5*d +: 5];
            if (dcode[d] != 5'(d + 1)) begin
                ident = 1'b0;
            end
        end

        n_result.buttons   = i_head.buttons;
        n_result.lt_level  = i_head.lt_level;
        n_result.rt_level  = i_head.rt_level;
        n_result.lx        = i_head.lx;
        n_result.ly        = i_head.ly;
        n_result.rx        = i_head.rx;
        n_result.ry        = i_head.ry;
        n_result.menu_fire = i_head.fire;

        if (i_head.suppressed) begin
            n_result.buttons  = 16'h0000;
            n_result.lt_level = 8'd0;
            n_result.rt_level = 8'd0;
            n_result.lx       = '0;
            n_result.ly       = '0;
            n_result.rx       = '0;
            n_result.ry       = '0;
        end else if (i_cfg.remap_enable && !ident) begin
            n_result.buttons = i_head.buttons & GUIDE_BIT;
            for (int d = 0; d < 14; d++) begin
                if (is_held(dcode[d], i_head.buttons, i_head.lt_level,
                            i_head.rt_level)) begin
                    n_result.buttons = n_result.buttons | code_bit(5'(d + 1));
                end
            end
            n_result.lt_level = level_of(dcode[14], i_head.buttons,
                                         i_head.lt_level, i_head.rt_level);
            n_result.rt_level = level_of(dcode[15], i_head.buttons,
                                         i_head.lt_level, i_head.rt_level);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

/* rtl/gamepad_remap_with_chord_detect.sv */
// channel | direction | handshake                 | payload
// poll    | in        | i_in_valid / o_in_ready   | i_pad_slot .. i_guest_suppressed
// result  | out       | o_out_valid / i_out_ready | o_out_buttons .. o_out_menu_fire
// config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One poll per cycle while o_in_ready is high; a taken poll is queued, then registered in the back stage.
// Chord state updates in the front stage as each poll is taken; remap runs in the back stage.
// A queue of DEPTH entries (default QUEUE_DEPTH) parts the two; o_in_ready drops only when it is full.
// Reset is synchronous, active low; configuration returns to defaults, queue empties.
// Config writes are taken in any cycle; o_cfg_ready stays high.
module gamepad_remap_with_chord_detect
    import grc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_pad_slot,
    input  logic [15:0]        i_raw_buttons,
    input  logic [7:0]         i_raw_left_trigger,
    input  logic [7:0]         i_raw_right_trigger,
    input  logic signed [15:0] i_stick_lx,
    input  logic signed [15:0] i_stick_ly,
    input  logic signed [15:0] i_stick_rx,
    input  logic signed [15:0] i_stick_ry,
    input  logic               i_guest_suppressed,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_out_buttons,
    output logic [7:0]         o_out_left_trigger,
    output logic [7:0]         o_out_right_trigger,
    output logic signed [15:0] o_out_lx,
    output logic signed [15:0] o_out_ly,
    output logic signed [15:0] o_out_rx,
    output logic signed [15:0] o_out_ry,
    output logic               o_out_menu_fire,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [39:0]        i_cfg_data
);

    t_cfg    r_cfg;
    logic    q_ready, push, pop, head_valid;
    t_item   front_item, head_item;
    t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.remap_enable   <= RST_REMAP_ENABLE;
            r_cfg.map_low        <= RST_MAP_LOW;
            r_cfg.map_high       <= RST_MAP_HIGH;
            r_cfg.chord_enable   <= RST_CHORD_ENABLE;
            r_cfg.chord_first    <= RST_CHORD_FIRST;
            r_cfg.chord_second   <= RST_CHORD_SECOND;
            r_cfg.hold_polls     <= RST_HOLD_POLLS;
            r_cfg.cooldown_polls <= RST_COOLDOWN_POLLS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_REMAP_ENABLE:   r_cfg.remap_enable   <= i_cfg_data[0];
                REG_MAP_LOW:        r_cfg.map_low        <= i_cfg_data;
                REG_MAP_HIGH:       r_cfg.map_high       <= i_cfg_data;
                REG_CHORD_ENABLE:   r_cfg.chord_enable   <= i_cfg_data[0];
                REG_CHORD_FIRST:    r_cfg.chord_first    <= i_cfg_data[4:0];
                REG_CHORD_SECOND:   r_cfg.chord_second   <= i_cfg_data[4:0];
                REG_HOLD_POLLS:     r_cfg.hold_polls     <= i_cfg_data[2:0];
                REG_COOLDOWN_POLLS: r_cfg.cooldown_polls <= i_cfg_data[5:0];
                default:            r_cfg.remap_enable   <= r_cfg.remap_enable;
            endcase
        end
    end

    grc_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_valid             (i_in_valid),
        .o_ready             (o_in_ready),
        .i_pad_slot          (i_pad_slot),
        .i_raw_buttons       (i_raw_buttons),
        .i_raw_left_trigger  (i_raw_left_trigger),
        .i_raw_right_trigger (i_raw_right_trigger),
        .i_stick_lx          (i_stick_lx),
        .i_stick_ly          (i_stick_ly),
        .i_stick_rx          (i_stick_rx),
        .i_stick_ry          (i_stick_ry),
        .i_guest_suppressed  (i_guest_suppressed),
        .i_queue_ready       (q_ready),
        .o_push              (push),
        .o_item              (front_item)
    );

    grc_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_item  (head_item)
    );

    grc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head_item),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_result     (result)
    );

    assign o_out_buttons       = result.buttons;
    assign o_out_left_trigger  = result.lt_level;
    assign o_out_right_trigger = result.rt_level;
    assign o_out_lx            = result.lx;
    assign o_out_ly            = result.ly;
    assign o_out_rx            = result.rx;
    assign o_out_ry            = result.ry;
    assign o_out_menu_fire     = result.menu_fire;

endmodule

/* rtl/grc_checker.sv */
`include "gamepad_remap_with_chord_detect_assert.svh"

module grc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [15:0]        o_out_buttons,
    input logic [7:0]         o_out_left_trigger,
    input logic [7:0]         o_out_right_trigger,
    input logic signed [15:0] o_out_lx,
    input logic               o_out_menu_fire
);

    logic [48:0] out_word;

    assign out_word = {o_out_buttons, o_out_left_trigger, o_out_right_trigger,
                       o_out_lx, o_out_menu_fire};

    `GRC_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `GRC_ASSERT(a_result_follows, i_in_valid && o_in_ready |=> ##1 o_out_valid, "result late")
    `GRC_ASSERT(a_full_means_stalled, !o_in_ready |-> o_out_valid, "queue full with output idle")
    `GRC_ASSERT(a_stall_holds, o_out_valid && !i_out_ready |=> o_out_valid && $stable(out_word), "stalled result changed")

endmodule

bind gamepad_remap_with_chord_detect grc_checker u_grc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_out_buttons       (o_out_buttons),
    .o_out_left_trigger  (o_out_left_trigger),
    .o_out_right_trigger (o_out_right_trigger),
    .o_out_lx            (o_out_lx),
    .o_out_menu_fire     (o_out_menu_fire)
);
